// ----- rtl/core/bounding_box_smoother_assert.svh -----
// Assertion macros for the bounding box smoother checker.
// Depends on nothing; included by the checker file.
`ifndef BOUNDING_BOX_SMOOTHER_ASSERT_SVH
`define BOUNDING_BOX_SMOOTHER_ASSERT_SVH
`define BBS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/bbs_pkg.sv -----
// Package for the bounding box smoother: register indexes and fixed-point constants.
// Depends on nothing.
package bbs_pkg;
  localparam logic [2:0] REG_OFS_X  = 3'd0;
  localparam logic [2:0] REG_OFS_Y  = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_MISS   = 3'd4;
  localparam logic signed [24:0] K_3P2 = 25'sd3355443;
  localparam logic signed [24:0] K_2P4 = 25'sd2516582;
  localparam logic signed [24:0] K_6P4 = 25'sd6710886;
  localparam logic signed [24:0] K_4P8 = 25'sd5033165;
  localparam int CAL_BITS = 15;
endpackage

// ----- rtl/core/bounding_box_smoother.sv -----
// Bounding box smoother: windowed mean box plus calibrated box per detection.
// A hit passes after acceptance through memory read and update, four serial divides
// by the fill count, a serial square root, three multiply and saturate steps and the output.
// The next item is taken once the result transaction completes; a miss passes through the clear
// state and gives no result.
// Synchronous reset clears the fill count, miss counter and sums; memory behind the fill count is ignored.
module bounding_box_smoother #(
  parameter int WINDOW_DEPTH = 8,
  parameter int COORD_BITS   = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         found,
  input  logic [COORD_BITS-1:0]        box_left,
  input  logic [COORD_BITS-1:0]        box_top,
  input  logic [COORD_BITS:0]          box_width,
  input  logic [COORD_BITS:0]          box_height,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COORD_BITS-1:0]        mean_left,
  output logic [COORD_BITS-1:0]        mean_top,
  output logic [COORD_BITS:0]          mean_width,
  output logic [COORD_BITS:0]          mean_height,
  output logic signed [COORD_BITS+3:0] cal_left,
  output logic signed [COORD_BITS+3:0] cal_top,
  output logic signed [COORD_BITS+3:0] cal_right,
  output logic signed [COORD_BITS+3:0] cal_bottom,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [15:0]                  cfg_data
);
  localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SB  = COORD_BITS + 1;
  localparam int CW  = COORD_BITS + 4;
  localparam int SUMW = SB + FW;
  localparam int RW  = SB + 8;
  localparam int RADW = 2 * RW;
  localparam int DIVN = SUMW;
  localparam int MEMW = 2 * COORD_BITS + 2 * SB;
  localparam logic signed [33:0] CAL_MAX = 34'((1 << (CW - 1)) - 1);
  localparam logic signed [33:0] CAL_MIN = -CAL_MAX - 34'sd1;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_UPD = 4'd2, S_DIV = 4'd3,
                         S_SQ = 4'd4, S_M1 = 4'd5, S_M2 = 4'd6, S_M3 = 4'd7,
                         S_OUT = 4'd8, S_CLR = 4'd9;

  logic [3:0] state;
  logic signed [15:0] ofs_x, ofs_y, w_ratio, h_ratio;
  logic [7:0] miss_limit, miss_count;
  logic [FW-1:0] fill_count;
  logic [AW-1:0] oldest, slot;
  logic [SUMW-1:0] sum [4];
  logic [COORD_BITS-1:0] bl, bt;
  logic [SB-1:0] bw, bh;

  logic we;
  logic [AW-1:0] waddr;
  logic [MEMW-1:0] wdata, rdata;

  bbs_ram #(.WIDTH(MEMW), .DEPTH(WINDOW_DEPTH), .AW(AW)) u_win (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(oldest), .rdata(rdata)
  );

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_stall  = (state != S_IDLE) || out_valid;
  wire in_acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_x <= '0;
      ofs_y <= '0;
      w_ratio <= 16'sd4096;
      h_ratio <= 16'sd4096;
      miss_limit <= 8'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bbs_pkg::REG_OFS_X:  ofs_x <= cfg_data;
        bbs_pkg::REG_OFS_Y:  ofs_y <= cfg_data;
        bbs_pkg::REG_WIDTH:  w_ratio <= cfg_data;
        bbs_pkg::REG_HEIGHT: h_ratio <= cfg_data;
        bbs_pkg::REG_MISS:   miss_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Serial divider over the four sums, and serial square root.
  logic [1:0] dsel;
  logic [$clog2(DIVN+1)-1:0] dstep;
  logic [SUMW-1:0] dq;
  logic [FW:0] drem;
  logic [SUMW-1:0] mean [4];
  logic [RADW-1:0] sq_n;
  logic [RW:0] sq_rem;
  logic [RW-1:0] sq_root;
  logic [$clog2(RW+1)-1:0] sq_step;
  logic signed [47:0] pdx, pdy, pcw, pch;
  logic signed [31:0] dx, dy, cw, ch;

  logic [FW:0] drem_sh;
  logic [RW+1:0] sq_try;
  logic [RW+1:0] sq_rsh;
  assign drem_sh = {drem[FW-1:0], dq[SUMW-1]};
  assign sq_rsh = {sq_rem[RW-1:0], sq_n[RADW-1 -: 2]};
  assign sq_try = sq_rsh - {sq_root, 2'b01};

  function automatic logic signed [31:0] trunc0(input logic signed [47:0] v);
    logic signed [47:0] a;
    a = v[47] ? -v : v;
    a = a >>> 20;
    return v[47] ? -a[31:0] : a[31:0];
  endfunction

  function automatic logic signed [CW-1:0] sat(input logic signed [33:0] v);
    if (v > CAL_MAX) return CAL_MAX[CW-1:0];
    if (v < CAL_MIN) return CAL_MIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  logic signed [33:0] cl, ct;
  assign cl = $signed(34'(mean[0][COORD_BITS-1:0])) + 34'(dx);
  assign ct = $signed(34'(mean[1][COORD_BITS-1:0])) + 34'(dy);

  always_comb begin
    we = 1'b0;
    waddr = slot;
    wdata = {bl, bt, bw, bh};
    if (state == S_CLR) begin
      we = 1'b0;
    end else if (state == S_UPD) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      miss_count <= '0;
      fill_count <= '0;
      oldest <= '0;
      for (int i = 0; i < 4; i++) sum[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            bl <= box_left; bt <= box_top; bw <= box_width; bh <= box_height;
            if (!found) begin
              state <= S_CLR;
              if (miss_count != 8'd255) miss_count <= miss_count + 8'd1;
            end else begin
              miss_count <= '0;
              state <= S_RD;
            end
          end
        end
        S_CLR: begin
          if (miss_count >= miss_limit) begin
            fill_count <= '0;
            oldest <= '0;
            for (int i = 0; i < 4; i++) sum[i] <= '0;
          end
          state <= S_IDLE;
        end
        S_RD: begin
          if (fill_count < FW'(WINDOW_DEPTH)) begin
            if (32'(oldest) + 32'(fill_count) >= WINDOW_DEPTH) begin
              slot <= AW'(32'(oldest) + 32'(fill_count) - WINDOW_DEPTH);
            end else begin
              slot <= AW'(32'(oldest) + 32'(fill_count));
            end
          end else begin
            slot <= oldest;
          end
          state <= S_UPD;
        end
        S_UPD: begin
          if (fill_count < FW'(WINDOW_DEPTH)) begin
            fill_count <= fill_count + 1'b1;
            sum[0] <= sum[0] + SUMW'(bl);
            sum[1] <= sum[1] + SUMW'(bt);
            sum[2] <= sum[2] + SUMW'(bw);
            sum[3] <= sum[3] + SUMW'(bh);
          end else begin
            oldest <= (32'(oldest) + 1 >= WINDOW_DEPTH) ? '0 : oldest + 1'b1;
            sum[0] <= sum[0] - SUMW'(rdata[MEMW-1 -: COORD_BITS]) + SUMW'(bl);
            sum[1] <= sum[1] - SUMW'(rdata[2*SB+COORD_BITS-1 -: COORD_BITS]) + SUMW'(bt);
            sum[2] <= sum[2] - SUMW'(rdata[2*SB-1 -: SB]) + SUMW'(bw);
            sum[3] <= sum[3] - SUMW'(rdata[SB-1:0]) + SUMW'(bh);
          end
          dsel <= '0;
          dstep <= '0;
          drem <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (dstep == '0) begin
            dq <= sum[dsel];
            drem <= '0;
            dstep <= dstep + 1'b1;
          end else begin
            if (drem_sh >= {1'b0, fill_count}) begin
              drem <= drem_sh - {1'b0, fill_count};
              dq <= {dq[SUMW-2:0], 1'b1};
            end else begin
              drem <= drem_sh;
              dq <= {dq[SUMW-2:0], 1'b0};
            end
            if (32'(dstep) == DIVN) begin
              dstep <= '0;
              mean[dsel] <= (drem_sh >= {1'b0, fill_count}) ? {dq[SUMW-2:0], 1'b1}
                                                         : {dq[SUMW-2:0], 1'b0};
              dsel <= dsel + 2'd1;
              if (dsel == 2'd3) begin
                sq_n <= RADW'({(2*SB)'(bw) * (2*SB)'(bh), 16'd0});
                sq_rem <= '0;
                sq_root <= '0;
                sq_step <= '0;
                state <= S_SQ;
              end
            end else begin
              dstep <= dstep + 1'b1;
            end
          end
        end
        S_SQ: begin
          if (!sq_try[RW+1]) begin
            sq_rem <= sq_try[RW:0];
            sq_root <= {sq_root[RW-2:0], 1'b1};
          end else begin
            sq_rem <= sq_rsh[RW:0];
            sq_root <= {sq_root[RW-2:0], 1'b0};
          end
          sq_n <= {sq_n[RADW-3:0], 2'b00};
          sq_step <= sq_step + 1'b1;
          if (32'(sq_step) == RW - 1) state <= S_M1;
        end
        S_M1: begin
          pdx <= 48'(ofs_x) * $signed({1'b0, sq_root}) - 48'(bbs_pkg::K_3P2);
          pdy <= 48'(ofs_y) * $signed({1'b0, sq_root}) - 48'(bbs_pkg::K_2P4);
          pcw <= ((48'(w_ratio) * $signed({1'b0, mean[2][SB-1:0]})) <<< 8)
                 + 48'(bbs_pkg::K_6P4);
          pch <= ((48'(h_ratio) * $signed({1'b0, mean[3][SB-1:0]})) <<< 8)
                 + 48'(bbs_pkg::K_4P8);
          state <= S_M2;
        end
        S_M2: begin
          dx <= trunc0(pdx); dy <= trunc0(pdy);
          cw <= trunc0(pcw); ch <= trunc0(pch);
          state <= S_M3;
        end
        S_M3: begin
          mean_left <= mean[0][COORD_BITS-1:0];
          mean_top <= mean[1][COORD_BITS-1:0];
          mean_width <= mean[2][SB-1:0];
          mean_height <= mean[3][SB-1:0];
          cal_left <= sat(cl);
          cal_top <= sat(ct);
          cal_right <= sat(cl + 34'(cw));
          cal_bottom <= sat(ct + 34'(ch));
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/bbs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module bbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/bbs_checker.sv -----
// Port-level checker for the bounding box smoother, bound to the top level.
// Depends on bounding_box_smoother_assert.svh.
`include "bounding_box_smoother_assert.svh"
module bbs_port_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic cfg_valid,
  input logic cfg_ready
);
  `BBS_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)
  `BBS_ASSERT_IMPL(a_cfg_idle, cfg_valid && cfg_ready, !in_stall)
  `BBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `BBS_ASSERT_IMPL(a_out_blocks, out_valid, in_stall)
endmodule

bind bounding_box_smoother bbs_port_checker u_bbs_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
